FILE: hdl/mpcb_pkg.sv
// Shared types and constants for the mode/priority callback table.
// Used by mpcb_cell, mpcb_ctrl and mode_priority_callback_table_core.
`default_nettype none
package mpcb_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam logic [1:0] KIND_REG   = 2'd0;
    localparam logic [1:0] KIND_UNREG = 2'd1;
    localparam logic [1:0] KIND_DISP  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_NOSPACE  = 3'd2,
        ST_EXISTS   = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_FAULT    = 3'd5
    } t_status;

    typedef struct packed {
        logic               valid;
        logic [3:0]         mode;
        logic signed [7:0]  prio;
        logic               phase;
        logic [15:0]        handle;
        logic [31:0]        ctx;
    } t_entry;

    // request broadcast to every cell for the compares
    typedef struct packed {
        logic [3:0]         mode;
        logic signed [7:0]  prio;
        logic               phase;
        logic [15:0]        handle;
    } t_req;

    typedef struct packed {
        logic valid;
        logic cand;   // empty, or same mode with lower priority
        logic same;   // exact match of a valid entry
        logic disp;   // valid, mode and phase match
    } t_flags;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_NEW,
        OP_LEFT,
        OP_RIGHT
    } t_cell_op;

endpackage
`default_nettype wire

FILE: hdl/mpcb_cell.sv
// One table slot: holds an entry, loads from its neighbors or a new entry.
// Depends on mpcb_pkg.
`default_nettype none
module mpcb_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mpcb_pkg::t_cell_op i_op,
    input  wire mpcb_pkg::t_req    i_req,
    input  wire mpcb_pkg::t_entry  i_new,
    input  wire mpcb_pkg::t_entry  i_left,
    input  wire mpcb_pkg::t_entry  i_right,
    output mpcb_pkg::t_entry       o_entry,
    output mpcb_pkg::t_flags       o_flags
);

    mpcb_pkg::t_entry r_entry;
    mpcb_pkg::t_entry n_entry;
    logic             w_mode_eq;

    always_comb begin
        case (i_op)
            mpcb_pkg::OP_NEW:   n_entry = i_new;
            mpcb_pkg::OP_LEFT:  n_entry = i_left;
            mpcb_pkg::OP_RIGHT: n_entry = i_right;
            default:            n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign w_mode_eq = (r_entry.mode == i_req.mode);

    always_comb begin
        o_flags.valid = r_entry.valid;
        o_flags.cand  = !r_entry.valid ||
                        (w_mode_eq && ($signed(r_entry.prio) < $signed(i_req.prio)));
        o_flags.same  = r_entry.valid && w_mode_eq && (r_entry.prio == i_req.prio) &&
                        (r_entry.phase == i_req.phase) && (r_entry.handle == i_req.handle);
        o_flags.disp  = r_entry.valid && w_mode_eq && (r_entry.phase == i_req.phase);
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

FILE: hdl/mpcb_ctrl.sv
// Sequencer for the callback table: scans the cell flags, drives the cell
// load controls and holds the output word register. Depends on mpcb_pkg.
`default_nettype none
module mpcb_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_valid,
    output logic                   o_s_ready,
    input  wire logic [1:0]        i_kind,
    input  wire mpcb_pkg::t_req    i_req,
    input  wire logic [31:0]       i_ctx,
    input  wire mpcb_pkg::t_flags  i_flags [mpcb_pkg::TABLE_DEPTH],
    input  wire mpcb_pkg::t_entry  i_head,
    output mpcb_pkg::t_cell_op     o_ops [mpcb_pkg::TABLE_DEPTH],
    output logic                   o_wrap,
    output mpcb_pkg::t_req         o_req,
    output mpcb_pkg::t_entry       o_new,
    output logic                   o_m_valid,
    input  wire logic              i_m_ready,
    output logic [2:0]             o_status,
    output logic                   o_cb_valid,
    output logic [15:0]            o_handle,
    output logic [31:0]            o_ctx,
    output logic                   o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DISP,
        S_STATUS
    } t_state;

    localparam logic [mpcb_pkg::IDX_W-1:0] LAST_IDX = mpcb_pkg::IDX_W'(mpcb_pkg::TABLE_DEPTH - 1);

    t_state                      r_state, n_state;
    logic [1:0]                  r_kind, n_kind;
    mpcb_pkg::t_req              r_req, n_req;
    logic [31:0]                 r_ctx, n_ctx;
    logic [mpcb_pkg::IDX_W-1:0]  r_idx, n_idx;
    mpcb_pkg::t_status           r_status, n_status;
    logic                        r_m_valid, n_m_valid;
    logic [2:0]                  r_o_status, n_o_status;
    logic                        r_o_cb, n_o_cb;
    logic [15:0]                 r_o_handle, n_o_handle;
    logic [31:0]                 r_o_ctx, n_o_ctx;
    logic                        r_o_last, n_o_last;

    logic                        w_out_free;
    logic                        w_at_end;

    assign w_out_free = !r_m_valid || i_m_ready;
    assign w_at_end   = (r_idx == LAST_IDX);

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_req      = r_req;
        n_ctx      = r_ctx;
        n_idx      = r_idx;
        n_status   = r_status;
        n_m_valid  = r_m_valid && !i_m_ready;
        n_o_status = r_o_status;
        n_o_cb     = r_o_cb;
        n_o_handle = r_o_handle;
        n_o_ctx    = r_o_ctx;
        n_o_last   = r_o_last;
        o_s_ready  = 1'b0;
        o_wrap     = 1'b0;
        for (int j = 0; j < mpcb_pkg::TABLE_DEPTH; j++) begin
            o_ops[j] = mpcb_pkg::OP_HOLD;
        end

        case (r_state)
            S_IDLE: begin
                // no word is taken while reset is held
                o_s_ready = i_rst_n;
                if (i_s_valid) begin
                    n_kind = i_kind;
                    n_req  = i_req;
                    n_ctx  = i_ctx;
                    n_idx  = '0;
                    case (i_kind)
                        mpcb_pkg::KIND_REG: begin
                            if (i_req.handle == 16'd0) begin
                                n_status = mpcb_pkg::ST_INVALID;
                                n_state  = S_STATUS;
                            end else if (i_flags[mpcb_pkg::TABLE_DEPTH-1].valid) begin
                                // packed table: last slot used means full
                                n_status = mpcb_pkg::ST_NOSPACE;
                                n_state  = S_STATUS;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        mpcb_pkg::KIND_UNREG: n_state = S_SCAN;
                        mpcb_pkg::KIND_DISP:  n_state = S_DISP;
                        default: begin
                            n_status = mpcb_pkg::ST_FAULT;
                            n_state  = S_STATUS;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_kind == mpcb_pkg::KIND_REG) begin
                    if (i_flags[r_idx].cand) begin
                        for (int j = 0; j < mpcb_pkg::TABLE_DEPTH; j++) begin
                            if (mpcb_pkg::IDX_W'(j) == r_idx) begin
                                o_ops[j] = mpcb_pkg::OP_NEW;
                            end else if (mpcb_pkg::IDX_W'(j) > r_idx) begin
                                o_ops[j] = mpcb_pkg::OP_LEFT;
                            end
                        end
                        n_status = mpcb_pkg::ST_OK;
                        n_state  = S_STATUS;
                    end else if (i_flags[r_idx].same) begin
                        n_status = mpcb_pkg::ST_EXISTS;
                        n_state  = S_STATUS;
                    end else if (w_at_end) begin
                        n_status = mpcb_pkg::ST_FAULT;
                        n_state  = S_STATUS;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    if (!i_flags[r_idx].valid) begin
                        n_status = mpcb_pkg::ST_NOTFOUND;
                        n_state  = S_STATUS;
                    end else if (i_flags[r_idx].same) begin
                        // close the gap; the last slot takes an empty entry
                        for (int j = 0; j < mpcb_pkg::TABLE_DEPTH; j++) begin
                            if (mpcb_pkg::IDX_W'(j) >= r_idx) begin
                                o_ops[j] = mpcb_pkg::OP_RIGHT;
                            end
                        end
                        n_status = mpcb_pkg::ST_OK;
                        n_state  = S_STATUS;
                    end else if (w_at_end) begin
                        n_status = mpcb_pkg::ST_NOTFOUND;
                        n_state  = S_STATUS;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_DISP: begin
                // rotate the ring once per step; slot 0 is examined each time
                if (!i_flags[0].disp || w_out_free) begin
                    o_wrap = 1'b1;
                    for (int j = 0; j < mpcb_pkg::TABLE_DEPTH; j++) begin
                        o_ops[j] = mpcb_pkg::OP_RIGHT;
                    end
                    if (i_flags[0].disp) begin
                        n_m_valid  = 1'b1;
                        n_o_status = mpcb_pkg::ST_OK;
                        n_o_cb     = 1'b1;
                        n_o_handle = i_head.handle;
                        n_o_ctx    = i_head.ctx;
                        n_o_last   = 1'b0;
                    end
                    if (w_at_end) begin
                        n_status = mpcb_pkg::ST_OK;
                        n_state  = S_STATUS;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_STATUS: begin
                if (w_out_free) begin
                    n_m_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_cb     = 1'b0;
                    n_o_handle = '0;
                    n_o_ctx    = '0;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            r_idx     <= '0;
            r_status  <= mpcb_pkg::ST_OK;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_idx     <= n_idx;
            r_status  <= n_status;
        end
        r_kind     <= n_kind;
        r_req      <= n_req;
        r_ctx      <= n_ctx;
        r_o_status <= n_o_status;
        r_o_cb     <= n_o_cb;
        r_o_handle <= n_o_handle;
        r_o_ctx    <= n_o_ctx;
        r_o_last   <= n_o_last;
    end

    always_comb begin
        o_new.valid  = 1'b1;
        o_new.mode   = r_req.mode;
        o_new.prio   = r_req.prio;
        o_new.phase  = r_req.phase;
        o_new.handle = r_req.handle;
        o_new.ctx    = r_ctx;
    end

    assign o_req      = r_req;
    assign o_m_valid  = r_m_valid;
    assign o_status   = r_o_status;
    assign o_cb_valid = r_o_cb;
    assign o_handle   = r_o_handle;
    assign o_ctx      = r_o_ctx;
    assign o_last     = r_o_last;

endmodule
`default_nettype wire

FILE: hdl/mode_priority_callback_table_core.sv
// Top level of the mode/priority callback table: a row of mpcb_cell slots
// and the mpcb_ctrl sequencer. Depends on mpcb_pkg, mpcb_cell, mpcb_ctrl.
//
// Usage:
//   Slave channel takes one request word: tuser holds the kind (register,
//   unregister, dispatch). Master channel returns result words: one per
//   dispatched callback (tuser high), then one status word with tlast high.
//   One request is worked on at a time; tready is high only when idle.
//   Register / unregister: the sequencer scans one slot per cycle until the
//   insertion point or match, then shifts the row in the cycle that finds it.
//   Dispatch: the row rotates one slot per cycle through slot 0 for
//   TABLE_DEPTH steps, except that it holds while a matching callback waits
//   for a busy output. The single output register lets steps that yield no
//   word run while a word waits. When the receiver stalls, status output
//   pauses; no word is lost or repeated. Reset (synchronous, active low)
//   empties every slot and returns the sequencer to idle; no clearing pass
//   is needed.
`default_nettype none
module mode_priority_callback_table_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [3:0] mode, [11:4] priority_req, [12] on_exit, [28:13] handle,
    // [60:29] context_req, [63:61] zero
    input  wire logic [63:0] s_axis_tdata,
    // [1:0] kind
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] status, [18:3] out_handle, [50:19] out_context, [55:51] zero
    output logic [55:0]      m_axis_tdata,
    // [0] callback_valid
    output logic [0:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    mpcb_pkg::t_req      w_in_req;
    mpcb_pkg::t_req      w_req;
    mpcb_pkg::t_entry    w_new;
    mpcb_pkg::t_entry    w_entry [mpcb_pkg::TABLE_DEPTH];
    mpcb_pkg::t_flags    w_flags [mpcb_pkg::TABLE_DEPTH];
    mpcb_pkg::t_cell_op  w_ops   [mpcb_pkg::TABLE_DEPTH];
    mpcb_pkg::t_entry    w_tail_in;
    logic                w_wrap;
    logic [2:0]          w_status;
    logic [15:0]         w_handle;
    logic [31:0]         w_ctx;

    always_comb begin
        w_in_req.mode   = s_axis_tdata[3:0];
        w_in_req.prio   = s_axis_tdata[11:4];
        w_in_req.phase  = s_axis_tdata[12];
        w_in_req.handle = s_axis_tdata[28:13];
    end

    // the last slot refills from slot 0 while rotating, else with an empty entry
    assign w_tail_in = w_wrap ? w_entry[0] : '0;

    genvar g;
    generate
        for (g = 0; g < mpcb_pkg::TABLE_DEPTH; g++) begin : g_cell
            mpcb_pkg::t_entry w_left;
            mpcb_pkg::t_entry w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_entry[g-1];
            end
            if (g == mpcb_pkg::TABLE_DEPTH - 1) begin : g_last
                assign w_right = w_tail_in;
            end else begin : g_mid_r
                assign w_right = w_entry[g+1];
            end
            mpcb_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_op    (w_ops[g]),
                .i_req   (w_req),
                .i_new   (w_new),
                .i_left  (w_left),
                .i_right (w_right),
                .o_entry (w_entry[g]),
                .o_flags (w_flags[g])
            );
        end
    endgenerate

    mpcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .o_s_ready  (s_axis_tready),
        .i_kind     (s_axis_tuser),
        .i_req      (w_in_req),
        .i_ctx      (s_axis_tdata[60:29]),
        .i_flags    (w_flags),
        .i_head     (w_entry[0]),
        .o_ops      (w_ops),
        .o_wrap     (w_wrap),
        .o_req      (w_req),
        .o_new      (w_new),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_status   (w_status),
        .o_cb_valid (m_axis_tuser[0]),
        .o_handle   (w_handle),
        .o_ctx      (w_ctx),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, w_ctx, w_handle, w_status};

endmodule
`default_nettype wire
